// ----- rtl/gnfe_pkg.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// gnfe_pkg
// Shared types and constants for the generic NACK FCI encoder.
// ---------------------------------------------------------------------------
package gnfe_pkg;

   localparam int unsigned MAX_PAIRS  = 255;
   localparam int unsigned SEQ_W      = 16;
   localparam int unsigned MASK_W     = 16;
   localparam int unsigned LEN_W      = 9;
   localparam int unsigned CNT_W      = $clog2(MAX_PAIRS + 1);
   // RTCP length counts the pairs plus the header and the two SSRC words, less one
   localparam int unsigned LEN_EXTRA  = 2;
   // response queue: an item can push two words
   localparam int unsigned FIFO_DEPTH = 4;
   localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
   localparam int unsigned FIFO_CW    = $clog2(FIFO_DEPTH + 1);
   localparam int unsigned PUSH_MAX   = 2;

   typedef struct packed {
      logic [SEQ_W-1:0] seq_num;
      logic             is_last;
   } req_type;

   typedef struct packed {
      logic [SEQ_W-1:0]  pid;
      logic [MASK_W-1:0] blp;
      logic              is_final;
      logic [LEN_W-1:0]  rtcp_length;
   } rsp_type;

   typedef struct packed {
      logic first;
      logic second;
   } push_type;

endpackage
`default_nettype wire

// ----- rtl/gnfe_rsp_fifo.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// gnfe_rsp_fifo
// Small response queue: takes up to two words a cycle, gives one while rsp_ready is high.
// ---------------------------------------------------------------------------
module gnfe_rsp_fifo (
   input  wire                           clock,
   input  wire                           reset,
   input  gnfe_pkg::push_type            push,
   input  gnfe_pkg::rsp_type             wr_data0,
   input  gnfe_pkg::rsp_type             wr_data1,
   output logic [gnfe_pkg::FIFO_CW-1:0]  level,
   output logic                          rsp_valid,
   input  wire                           rsp_ready,
   output gnfe_pkg::rsp_type             rsp_data
);

   gnfe_pkg::rsp_type                mem_ff [gnfe_pkg::FIFO_DEPTH];
   logic [gnfe_pkg::FIFO_AW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [gnfe_pkg::FIFO_AW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [gnfe_pkg::FIFO_CW-1:0]     count_ff, count_in;
   logic [gnfe_pkg::FIFO_AW-1:0]     wr_ptr_next;
   logic                             pop;
   logic [gnfe_pkg::FIFO_CW-1:0]     n_push;

   assign pop         = (count_ff != '0) && rsp_ready;
   assign wr_ptr_next = wr_ptr_ff + gnfe_pkg::FIFO_AW'(1);
   assign n_push      = gnfe_pkg::FIFO_CW'(push.first) + gnfe_pkg::FIFO_CW'(push.second);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + gnfe_pkg::FIFO_AW'(n_push);
      rd_ptr_in = rd_ptr_ff + gnfe_pkg::FIFO_AW'(pop);
      count_in  = count_ff + n_push - gnfe_pkg::FIFO_CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // second word only ever follows a first one
   always_ff @(posedge clock) begin
      if (push.first) begin
         mem_ff[wr_ptr_ff] <= wr_data0;
      end
      if (push.second) begin
         mem_ff[wr_ptr_next] <= wr_data1;
      end
   end

   assign level     = count_ff;
   assign rsp_valid = (count_ff != '0);
   assign rsp_data  = mem_ff[rd_ptr_ff];

endmodule
`default_nettype wire

// ----- rtl/generic_nack_fci_encoder_top.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// generic_nack_fci_encoder_top
// Packs ascending lost RTP sequence numbers into RTCP generic NACK pairs.
// ---------------------------------------------------------------------------
// One lost sequence number is taken per word on the req channel, and the
// block can take one every cycle. Each accepted word is compared against the
// open pair in the same cycle and yields zero, one or two result words (a
// closed pair, then the final pair when is_last is set), which go into a
// four-word response queue. req_ready is high while the queue has room for
// two words, so the input side stalls only when the rsp side is held off;
// the rsp side drains one word per cycle while rsp_ready is high; rsp_valid
// comes from the registered queue count. The word marked is_last flushes the
// open pair with the RTCP length field and returns the pair state to reset.
// ---------------------------------------------------------------------------
module generic_nack_fci_encoder_top (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_ready,
   input  gnfe_pkg::req_type    req_data,
   output logic                 rsp_valid,
   input  wire                  rsp_ready,
   output gnfe_pkg::rsp_type    rsp_data
);

   logic                           pair_open_ff, pair_open_in;
   logic [gnfe_pkg::SEQ_W-1:0]     open_pid_ff, open_pid_in;
   logic [gnfe_pkg::MASK_W-1:0]    open_mask_ff, open_mask_in;
   logic [gnfe_pkg::CNT_W-1:0]     pair_count_ff, pair_count_in;

   logic                           accept;
   logic [gnfe_pkg::SEQ_W:0]       diff;
   logic [3:0]                     bit_idx;
   logic                           is_near;
   logic                           room;
   logic                           close_pair;
   logic [gnfe_pkg::SEQ_W-1:0]     upd_pid;
   logic [gnfe_pkg::MASK_W-1:0]    upd_mask;
   logic [gnfe_pkg::CNT_W-1:0]     upd_count;
   gnfe_pkg::rsp_type              closed_word;
   gnfe_pkg::rsp_type              final_word;
   gnfe_pkg::rsp_type              wr_data0;
   gnfe_pkg::push_type             push;
   logic [gnfe_pkg::FIFO_CW-1:0]   level;

   assign req_ready = (level <= gnfe_pkg::FIFO_CW'(gnfe_pkg::FIFO_DEPTH - gnfe_pkg::PUSH_MAX));
   assign accept    = req_valid && req_ready;

   always_comb begin
      diff       = {1'b0, req_data.seq_num} - {1'b0, open_pid_ff};
      bit_idx    = 4'(diff[4:0] - 5'd1);
      is_near    = (req_data.seq_num > open_pid_ff) && (diff <= 17'd16);
      room       = (pair_count_ff < gnfe_pkg::CNT_W'(gnfe_pkg::MAX_PAIRS));
      close_pair = pair_open_ff && !is_near && room;

      upd_pid   = open_pid_ff;
      upd_mask  = open_mask_ff;
      upd_count = pair_count_ff;
      if (!pair_open_ff) begin
         upd_pid   = req_data.seq_num;
         upd_mask  = '0;
         upd_count = gnfe_pkg::CNT_W'(1);
      end else if (is_near) begin
         upd_mask = open_mask_ff | (gnfe_pkg::MASK_W'(1) << bit_idx);
      end else if (room) begin
         upd_pid   = req_data.seq_num;
         upd_mask  = '0;
         upd_count = pair_count_ff + gnfe_pkg::CNT_W'(1);
      end
      // at the pair limit a far entry is dropped and the open pair kept

      closed_word.pid         = open_pid_ff;
      closed_word.blp         = open_mask_ff;
      closed_word.is_final    = 1'b0;
      closed_word.rtcp_length = '0;

      final_word.pid         = upd_pid;
      final_word.blp         = upd_mask;
      final_word.is_final    = 1'b1;
      final_word.rtcp_length = gnfe_pkg::LEN_W'(32'(upd_count) + 32'(gnfe_pkg::LEN_EXTRA));

      wr_data0    = close_pair ? closed_word : final_word;
      push.first  = accept && (close_pair || req_data.is_last);
      push.second = accept && close_pair && req_data.is_last;

      pair_open_in  = pair_open_ff;
      open_pid_in   = open_pid_ff;
      open_mask_in  = open_mask_ff;
      pair_count_in = pair_count_ff;
      if (accept) begin
         if (req_data.is_last) begin
            pair_open_in  = 1'b0;
            open_pid_in   = '0;
            open_mask_in  = '0;
            pair_count_in = '0;
         end else begin
            pair_open_in  = 1'b1;
            open_pid_in   = upd_pid;
            open_mask_in  = upd_mask;
            pair_count_in = upd_count;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pair_open_ff  <= 1'b0;
         open_pid_ff   <= '0;
         open_mask_ff  <= '0;
         pair_count_ff <= '0;
      end else begin
         pair_open_ff  <= pair_open_in;
         open_pid_ff   <= open_pid_in;
         open_mask_ff  <= open_mask_in;
         pair_count_ff <= pair_count_in;
      end
   end

   gnfe_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .wr_data0  (wr_data0),
      .wr_data1  (final_word),
      .level     (level),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   a_level_bound : assert property (@(posedge clock) disable iff (reset)
      level <= gnfe_pkg::FIFO_CW'(gnfe_pkg::FIFO_DEPTH))
      else $error("response queue overfilled");

   a_last_clears : assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.is_last) |=> (!pair_open_ff && (pair_count_ff == '0)))
      else $error("pair state not cleared after last word");

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      pair_count_ff <= gnfe_pkg::CNT_W'(gnfe_pkg::MAX_PAIRS))
      else $error("pair count beyond limit");

   a_open_count : assert property (@(posedge clock) disable iff (reset)
      pair_open_ff == (pair_count_ff != '0))
      else $error("open flag and pair count disagree");

endmodule
`default_nettype wire

// ----- dv/generic_nack_fci_encoder_top_test.sv -----
// ---------------------------------------------------------------------------
// generic_nack_fci_encoder_top_test
// Streams lists of lost sequence numbers into the NACK encoder, predicts the
// feedback pairs each word yields and checks every response word in order.
// ---------------------------------------------------------------------------
module generic_nack_fci_encoder_top_test;

   // a packet ID covers the sixteen sequence numbers above it
   localparam int unsigned MASK_SPAN   = 16;
   localparam int unsigned CYCLE_LIMIT = 600000;
   localparam int unsigned HOLD_CYCLES = 300;
   localparam int unsigned HOLD_STEP   = 60;
   localparam int unsigned HOLD_COUNT  = 2;
   localparam int unsigned PRINT_MAX   = 40;

   typedef struct {
      gnfe_pkg::req_type word;
      bit                drain;
   } loss_word_type;

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   gnfe_pkg::req_type req_data  = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   gnfe_pkg::rsp_type rsp_data;

   loss_word_type      loss_pending[$];
   gnfe_pkg::rsp_type  nack_expected[$];

   // predictor state
   bit          nack_open  = 1'b0;
   logic [15:0] nack_pid   = '0;
   logic [15:0] nack_mask  = '0;
   int unsigned nack_pairs = 0;

   int unsigned errors      = 0;
   int unsigned cycles      = 0;
   int unsigned words_total = 0;
   int unsigned words_taken = 0;
   int unsigned rsp_seen    = 0;
   bit          req_took    = 1'b0;
   int unsigned req_gap     = 0;
   int unsigned req_run     = 0;
   int unsigned rsp_stall   = 0;
   int unsigned rsp_run     = 0;
   int unsigned holds_done  = 0;

   generic_nack_fci_encoder_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   task automatic report_mismatch(input string what);
      errors++;
      if (errors <= PRINT_MAX) begin
         $display("mismatch at cycle %0d: %s", cycles, what);
      end
   endtask

   // mostly short gaps, a few long ones, and now and then a stretch of none
   function automatic int unsigned draw_gap(inout int unsigned run_left);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (run_left != 0) begin
         run_left--;
         return 0;
      end
      if (r < 6) begin
         run_left = $urandom_range(30, 90);
         return 0;
      end
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic pack_loss(input gnfe_pkg::req_type w);
      int unsigned       reach;
      gnfe_pkg::rsp_type r;
      if (!nack_open) begin
         nack_open  = 1'b1;
         nack_pid   = w.seq_num;
         nack_mask  = '0;
         nack_pairs = 1;
      end else begin
         // equal or smaller numbers count as out of reach
         reach = MASK_SPAN + 1;
         if (w.seq_num > nack_pid) reach = int'(w.seq_num) - int'(nack_pid);
         if (reach > MASK_SPAN) begin
            // at the pair limit drop the word and keep the open pair
            if (nack_pairs < gnfe_pkg::MAX_PAIRS) begin
               r.pid         = nack_pid;
               r.blp         = nack_mask;
               r.is_final    = 1'b0;
               r.rtcp_length = '0;
               nack_expected.push_back(r);
               nack_pid   = w.seq_num;
               nack_mask  = '0;
               nack_pairs++;
            end
         end else begin
            nack_mask[reach-1] = 1'b1;
         end
      end
      if (w.is_last) begin
         r.pid         = nack_pid;
         r.blp         = nack_mask;
         r.is_final    = 1'b1;
         r.rtcp_length = gnfe_pkg::LEN_W'(nack_pairs + gnfe_pkg::LEN_EXTRA);
         nack_expected.push_back(r);
         nack_open  = 1'b0;
         nack_pid   = '0;
         nack_mask  = '0;
         nack_pairs = 0;
      end
   endtask

   task automatic add_loss(input logic [15:0] seq, input logic last, input bit drain);
      loss_word_type e;
      e.word.seq_num = seq;
      e.word.is_last = last;
      e.drain        = drain;
      loss_pending.push_back(e);
      words_total++;
   endtask

   // driver: a word with the drain mark waits until every pair has come back
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_gap   <= 0;
      end else if (!req_valid || req_took) begin
         if (req_gap != 0) begin
            req_valid <= 1'b0;
            req_gap   <= req_gap - 1;
         end else if (loss_pending.size() != 0 &&
                      !(loss_pending[0].drain && nack_expected.size() != 0)) begin
            req_data  <= loss_pending[0].word;
            req_valid <= 1'b1;
            req_gap   <= draw_gap(req_run);
            loss_pending.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver: random stalls, plus long hold-offs once enough words are back
   always @(negedge clock) begin
      int unsigned gap;
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_stall <= 0;
      end else if (rsp_stall != 0) begin
         rsp_ready <= 1'b0;
         rsp_stall <= rsp_stall - 1;
      end else if (holds_done < HOLD_COUNT && rsp_seen >= (holds_done + 1) * HOLD_STEP) begin
         rsp_ready  <= 1'b0;
         rsp_stall  <= HOLD_CYCLES - 1;
         holds_done <= holds_done + 1;
      end else begin
         gap = draw_gap(rsp_run);
         if (gap == 0) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b0;
            rsp_stall <= gap - 1;
         end
      end
   end

   // monitor: check the response first, then predict from the request
   always @(posedge clock) begin
      gnfe_pkg::rsp_type want;
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("TB_ERROR");
         $finish;
      end else if (reset) begin
         req_took <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            rsp_seen++;
            if (nack_expected.size() == 0) begin
               report_mismatch($sformatf("unexpected word pid %h blp %h",
                                         rsp_data.pid, rsp_data.blp));
            end else begin
               want = nack_expected.pop_front();
               if (rsp_data.pid !== want.pid)
                  report_mismatch($sformatf("pid %h, want %h", rsp_data.pid, want.pid));
               if (rsp_data.blp !== want.blp)
                  report_mismatch($sformatf("blp %h, want %h", rsp_data.blp, want.blp));
               if (rsp_data.is_final !== want.is_final)
                  report_mismatch($sformatf("is_final %b, want %b",
                                            rsp_data.is_final, want.is_final));
               if (rsp_data.rtcp_length !== want.rtcp_length)
                  report_mismatch($sformatf("rtcp_length %0d, want %0d",
                                            rsp_data.rtcp_length, want.rtcp_length));
            end
         end
         if (req_valid && req_ready) begin
            pack_loss(req_data);
            words_taken++;
         end
         req_took <= req_valid && req_ready;
      end
   end

   initial begin
      int unsigned len;
      int unsigned r;
      int unsigned far_cnt;
      int unsigned random_cnt;
      logic [15:0] seq;
      bit          long_done;

      // single-word messages at both ends of the range
      add_loss(16'h0000, 1'b1, 1'b0);
      add_loss(16'hFFFF, 1'b1, 1'b0);
      // edges of the mask window, a repeat and a step back
      add_loss(16'd100, 1'b0, 1'b0);
      add_loss(16'd101, 1'b0, 1'b0);
      add_loss(16'd116, 1'b0, 1'b0);
      add_loss(16'd117, 1'b0, 1'b0);
      add_loss(16'd117, 1'b0, 1'b0);
      add_loss(16'd50,  1'b0, 1'b0);
      add_loss(16'd66,  1'b0, 1'b0);
      add_loss(16'd67,  1'b1, 1'b0);
      // closing pair and final pair from the same word
      add_loss(16'h0000, 1'b0, 1'b1);
      add_loss(16'h0001, 1'b0, 1'b0);
      add_loss(16'h8000, 1'b1, 1'b0);
      // wrap past the top of the range
      add_loss(16'hFFF0, 1'b0, 1'b0);
      add_loss(16'hFFFF, 1'b0, 1'b0);
      add_loss(16'h0000, 1'b1, 1'b0);
      add_loss(16'h7FFF, 1'b0, 1'b0);
      add_loss(16'h800F, 1'b1, 1'b0);

      random_cnt = 0;
      long_done  = 1'b0;
      while (random_cnt < 150 || !long_done) begin
         if (!long_done && random_cnt >= 75) begin
            // run the message past the pair limit so later far words drop
            seq     = 16'($urandom_range(0, 500));
            far_cnt = 0;
            add_loss(seq, 1'b0, 1'b1);
            while (far_cnt < gnfe_pkg::MAX_PAIRS + 5) begin
               if ($urandom_range(0, 99) < 20) begin
                  seq = seq + 16'($urandom_range(1, 16));
               end else begin
                  seq = seq + 16'($urandom_range(17, 190));
                  far_cnt++;
               end
               add_loss(seq, far_cnt == gnfe_pkg::MAX_PAIRS + 5, 1'b0);
            end
            long_done = 1'b1;
         end else begin
            len = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 10) : $urandom_range(11, 40);
            seq = 16'($urandom_range(0, 65535));
            for (int i = 0; i < len; i++) begin
               if (i != 0) begin
                  r = $urandom_range(0, 99);
                  if (r < 70)      seq = seq + 16'($urandom_range(1, 16));
                  else if (r < 85) seq = seq + 16'($urandom_range(17, 300));
                  else if (r >= 93) seq = seq - 16'($urandom_range(1, 100));
               end
               add_loss(seq, i == len - 1, i == 0 && $urandom_range(0, 14) == 0);
            end
            random_cnt += len;
         end
      end

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (words_taken != words_total) @(negedge clock);
      while (nack_expected.size() != 0) @(negedge clock);
      repeat (16) @(negedge clock);
      if (errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// ----- files.f -----
rtl/gnfe_pkg.sv
rtl/gnfe_rsp_fifo.sv
rtl/generic_nack_fci_encoder_top.sv
dv/generic_nack_fci_encoder_top_test.sv
